/* rtl/core/gn3_pkg.sv */
package gn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW = 22;
  localparam int PW = 48;
  localparam int OUT_MAX = 131072;
  localparam int OUT_MIN = -131072;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  localparam val_t VAL_ONE = val_t'(64'sd1 <<< FRAC_BITS);

  function automatic val_t fx_round(input prod_t p);
    prod_t q;
    q = p + (prod_t'(1) <<< (FRAC_BITS - 1));
    return q[FRAC_BITS +: VW];
  endfunction

  function automatic val_t fx_mul(input val_t a, input val_t b);
    return fx_round(prod_t'(a) * prod_t'(b));
  endfunction

  function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y,
                                input val_t z);
    val_t u;
    val_t v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h inside {4'd12, 4'd14}) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic val_t lerp(input val_t w, input val_t a, input val_t b);
    return a + fx_mul(w, b - a);
  endfunction

endpackage

/* rtl/core/gn3_ram.sv */
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/gn3_fade.sv */
module gn3_fade
  import gn3_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] t,
  output val_t        fade
);

  val_t tv;
  val_t t_a;
  val_t p1;
  val_t t2;
  val_t t3;
  val_t inner;

  assign tv = val_t'({1'b0, t});

  always_ff @(posedge clk) begin
    t_a   <= tv;
    p1    <= fx_mul(tv, val_t'(6) * tv - val_t'(15) * VAL_ONE);
    t2    <= fx_mul(tv, tv);
    t3    <= fx_mul(t2, t_a);
    inner <= p1 + val_t'(10) * VAL_ONE;
    fade  <= fx_mul(t3, inner);
  end

endmodule

/* rtl/core/gradient_noise_3d.sv */
// Channel  | Handshake                       | Payload
// request  | start, busy (accepted when      | operation, coord_x, coord_y, coord_z,
//          | start is high and busy is low)  | entry_index, entry_value
// result   | strobe (one cycle, no stall)    | noise_value
//
// One request is taken every cycle; busy is always low.
// An evaluate request gives its result when its valid bit has passed v1 to v6 and reaches strobe.
// A write request gives no result; the table is held in seven copies, and each
// copy is written in the cycle that lines up with its read stage.
// Reset clears the valid bits only; the table must be loaded before use.
module gradient_noise_3d
  import gn3_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         entry_value,
  output logic               strobe,
  output logic signed [18:0] noise_value
);

  logic       ev0;
  logic       wr0;
  logic       v1, v2, v3, v4, v5, v6;
  logic       w1, w2;
  logic [7:0] wi1, wi2, wd1, wd2;
  logic [15:0] fx1, fy1, fz1, fx2, fy2, fz2, fx3, fy3, fz3;
  logic [7:0] y1, z1, z2;
  logic [7:0] px_a, px_b;
  logic [7:0] a_idx, b_idx;
  logic [7:0] pa_a, pa_b, pb_a, pb_b;
  logic [7:0] aa_idx, ab_idx, ba_idx, bb_idx;
  logic [7:0] h_aa, h_aa1, h_ab, h_ab1, h_ba, h_ba1, h_bb, h_bb1;
  val_t       fu, fv, fw;
  val_t       xv, yv, zv, xm, ym, zm;
  val_t       g [8];
  val_t       l [4];
  val_t       m [2];
  val_t       v5f, w5f, w6f;
  val_t       r;

  assign busy = 1'b0;
  assign ev0  = start && !busy && (operation == OP_EVAL);
  assign wr0  = start && !busy && (operation == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      strobe <= 1'b0;
      w1 <= 1'b0;
      w2 <= 1'b0;
    end else begin
      v1 <= ev0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      strobe <= v6;
      w1 <= wr0;
      w2 <= w1;
    end
  end

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_x (
    .clk(clk), .we(wr0), .waddr(entry_index), .wdata(entry_value),
    .raddr_a(coord_x[23:16]), .raddr_b(coord_x[23:16] + 8'd1),
    .rdata_a(px_a), .rdata_b(px_b)
  );

  always_ff @(posedge clk) begin
    wi1 <= entry_index;
    wd1 <= entry_value;
    wi2 <= wi1;
    wd2 <= wd1;
    fx1 <= coord_x[15:0];
    fy1 <= coord_y[15:0];
    fz1 <= coord_z[15:0];
    y1  <= coord_y[23:16];
    z1  <= coord_z[23:16];
    fx2 <= fx1;
    fy2 <= fy1;
    fz2 <= fz1;
    z2  <= z1;
    fx3 <= fx2;
    fy3 <= fy2;
    fz3 <= fz2;
  end

  assign a_idx = px_a + y1;
  assign b_idx = px_b + y1;

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_a (
    .clk(clk), .we(w1), .waddr(wi1), .wdata(wd1),
    .raddr_a(a_idx), .raddr_b(a_idx + 8'd1), .rdata_a(pa_a), .rdata_b(pa_b)
  );

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_b (
    .clk(clk), .we(w1), .waddr(wi1), .wdata(wd1),
    .raddr_a(b_idx), .raddr_b(b_idx + 8'd1), .rdata_a(pb_a), .rdata_b(pb_b)
  );

  assign aa_idx = pa_a + z2;
  assign ab_idx = pa_b + z2;
  assign ba_idx = pb_a + z2;
  assign bb_idx = pb_b + z2;

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_aa (
    .clk(clk), .we(w2), .waddr(wi2), .wdata(wd2),
    .raddr_a(aa_idx), .raddr_b(aa_idx + 8'd1), .rdata_a(h_aa), .rdata_b(h_aa1)
  );

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_ab (
    .clk(clk), .we(w2), .waddr(wi2), .wdata(wd2),
    .raddr_a(ab_idx), .raddr_b(ab_idx + 8'd1), .rdata_a(h_ab), .rdata_b(h_ab1)
  );

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_ba (
    .clk(clk), .we(w2), .waddr(wi2), .wdata(wd2),
    .raddr_a(ba_idx), .raddr_b(ba_idx + 8'd1), .rdata_a(h_ba), .rdata_b(h_ba1)
  );

  gn3_ram #(.WIDTH(8), .DEPTH(256)) u_ram_bb (
    .clk(clk), .we(w2), .waddr(wi2), .wdata(wd2),
    .raddr_a(bb_idx), .raddr_b(bb_idx + 8'd1), .rdata_a(h_bb), .rdata_b(h_bb1)
  );

  gn3_fade u_fade_x (.clk(clk), .t(fx1), .fade(fu));
  gn3_fade u_fade_y (.clk(clk), .t(fy1), .fade(fv));
  gn3_fade u_fade_z (.clk(clk), .t(fz1), .fade(fw));

  assign xv = val_t'({1'b0, fx3});
  assign yv = val_t'({1'b0, fy3});
  assign zv = val_t'({1'b0, fz3});
  assign xm = xv - VAL_ONE;
  assign ym = yv - VAL_ONE;
  assign zm = zv - VAL_ONE;

  always_ff @(posedge clk) begin
    g[0] <= grad(h_aa[3:0],  xv, yv, zv);
    g[1] <= grad(h_ba[3:0],  xm, yv, zv);
    g[2] <= grad(h_ab[3:0],  xv, ym, zv);
    g[3] <= grad(h_bb[3:0],  xm, ym, zv);
    g[4] <= grad(h_aa1[3:0], xv, yv, zm);
    g[5] <= grad(h_ba1[3:0], xm, yv, zm);
    g[6] <= grad(h_ab1[3:0], xv, ym, zm);
    g[7] <= grad(h_bb1[3:0], xm, ym, zm);
    l[0] <= lerp(fu, g[0], g[1]);
    l[1] <= lerp(fu, g[2], g[3]);
    l[2] <= lerp(fu, g[4], g[5]);
    l[3] <= lerp(fu, g[6], g[7]);
    v5f  <= fv;
    w5f  <= fw;
    m[0] <= lerp(v5f, l[0], l[1]);
    m[1] <= lerp(v5f, l[2], l[3]);
    w6f  <= w5f;
  end

  assign r = lerp(w6f, m[0], m[1]);

  always_ff @(posedge clk) begin
    if (r > val_t'(OUT_MAX)) begin
      noise_value <= 19'(OUT_MAX);
    end else if (r < val_t'(OUT_MIN)) begin
      noise_value <= 19'(OUT_MIN);
    end else begin
      noise_value <= r[18:0];
    end
  end

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(v1, 6))
    else $error("result without an evaluate request");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    wr0 |=> !v1)
    else $error("write request entered the evaluate pipeline");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (noise_value <= 19'sd131072 && noise_value >= -19'sd131072))
    else $error("result outside the saturation range");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule
